>>> rtl/core/gmb_pkg.sv
// Shared types and constants for the growth / mutation birth-step block.
// Register map, reset values, request kinds and the configuration bundle.
// No dependencies.
`default_nettype none

package gmb_pkg;

   localparam int CFG_W     = 32;
   localparam int IDX_W     = 3;
   localparam int FIELD_W   = 32;
   localparam int REQ_DATA_W = 6 * FIELD_W;
   localparam int RSP_DATA_W = 4 * FIELD_W;
   localparam int RSP_USER_W = 2;

   localparam int DEFAULT_COUNT_BITS = 32;
   localparam int DEFAULT_FRAC_BITS  = 32;

   localparam logic [IDX_W-1:0] REG_THR_N_ANY = 3'd0;
   localparam logic [IDX_W-1:0] REG_THR_N_A   = 3'd1;
   localparam logic [IDX_W-1:0] REG_THR_A_ONE = 3'd2;
   localparam logic [IDX_W-1:0] REG_THR_A_TWO = 3'd3;
   localparam logic [IDX_W-1:0] REG_THR_M_ONE = 3'd4;
   localparam logic [IDX_W-1:0] REG_THR_M_TWO = 3'd5;
   localparam logic [IDX_W-1:0] REG_MAX_TOTAL = 3'd6;

   localparam logic [CFG_W-1:0] RST_THR_N_ANY = 32'd4724;
   localparam logic [CFG_W-1:0] RST_THR_N_A   = 32'd429;
   localparam logic [CFG_W-1:0] RST_THR_A_ONE = 32'd8590;
   localparam logic [CFG_W-1:0] RST_THR_A_TWO = 32'd0;
   localparam logic [CFG_W-1:0] RST_THR_M_ONE = 32'd85899;
   localparam logic [CFG_W-1:0] RST_THR_M_TWO = 32'd0;
   localparam logic [CFG_W-1:0] RST_MAX_TOTAL = 32'h8000_0000;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_BIRTH = 1'b1;

   typedef struct packed {
      logic [CFG_W-1:0] thr_n_mutate_any;
      logic [CFG_W-1:0] thr_n_mutate_a;
      logic [CFG_W-1:0] thr_a_one;
      logic [CFG_W-1:0] thr_a_two;
      logic [CFG_W-1:0] thr_m_one;
      logic [CFG_W-1:0] thr_m_two;
      logic [CFG_W-1:0] max_total;
   } cfg_type;

endpackage

`default_nettype wire

>>> rtl/core/gmb_csr.sv
// Configuration register file: thresholds and growth limit.
// Depends on gmb_pkg for the register map and reset values.
`default_nettype none

module gmb_csr (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_wen,
   input  wire logic [gmb_pkg::IDX_W-1:0]  csr_index,
   input  wire logic [gmb_pkg::CFG_W-1:0]  csr_wdata,
   output gmb_pkg::cfg_type                cfg_o
);
   import gmb_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            REG_THR_N_ANY: cfg_in.thr_n_mutate_any = csr_wdata;
            REG_THR_N_A:   cfg_in.thr_n_mutate_a   = csr_wdata;
            REG_THR_A_ONE: cfg_in.thr_a_one        = csr_wdata;
            REG_THR_A_TWO: cfg_in.thr_a_two        = csr_wdata;
            REG_THR_M_ONE: cfg_in.thr_m_one        = csr_wdata;
            REG_THR_M_TWO: cfg_in.thr_m_two        = csr_wdata;
            REG_MAX_TOTAL: cfg_in.max_total        = csr_wdata;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.thr_n_mutate_any <= RST_THR_N_ANY;
         cfg_ff.thr_n_mutate_a   <= RST_THR_N_A;
         cfg_ff.thr_a_one        <= RST_THR_A_ONE;
         cfg_ff.thr_a_two        <= RST_THR_A_TWO;
         cfg_ff.thr_m_one        <= RST_THR_M_ONE;
         cfg_ff.thr_m_two        <= RST_THR_M_TWO;
         cfg_ff.max_total        <= RST_MAX_TOTAL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg_o = cfg_ff;

endmodule

`default_nettype wire

>>> rtl/core/gmb_step.sv
// Next-state logic for one request: load or birth event on the four counts.
// Depends on gmb_pkg for the configuration bundle and request kinds.
`default_nettype none

module gmb_step #(
   parameter int COUNT_BITS = gmb_pkg::DEFAULT_COUNT_BITS,
   parameter int FRAC_BITS  = gmb_pkg::DEFAULT_FRAC_BITS
) (
   input  gmb_pkg::cfg_type                 cfg_i,
   input  wire logic                        func_i,
   input  wire logic [gmb_pkg::FIELD_W-1:0] load_normal_i,
   input  wire logic [gmb_pkg::FIELD_W-1:0] load_a_i,
   input  wire logic [gmb_pkg::FIELD_W-1:0] load_m_i,
   input  wire logic [gmb_pkg::FIELD_W-1:0] load_double_i,
   input  wire logic [gmb_pkg::FIELD_W-1:0] rand_pick_i,
   input  wire logic [gmb_pkg::FIELD_W-1:0] rand_second_i,
   input  wire logic [COUNT_BITS-1:0]       normal_i,
   input  wire logic [COUNT_BITS-1:0]       a_i,
   input  wire logic [COUNT_BITS-1:0]       m_i,
   input  wire logic [COUNT_BITS-1:0]       double_i,
   output logic      [COUNT_BITS-1:0]       normal_o,
   output logic      [COUNT_BITS-1:0]       a_o,
   output logic      [COUNT_BITS-1:0]       m_o,
   output logic      [COUNT_BITS-1:0]       double_o,
   output logic                             full_o,
   output logic                             extinct_o
);
   import gmb_pkg::*;

   localparam int TOT_W  = COUNT_BITS + 2;
   localparam int PROD_W = TOT_W + FRAC_BITS;
   localparam int CMP_W  = (TOT_W > CFG_W) ? TOT_W : CFG_W;
   localparam int FEXT_W = (FRAC_BITS > FIELD_W) ? FRAC_BITS : FIELD_W;
   localparam int CEXT_W = (COUNT_BITS > FIELD_W) ? COUNT_BITS : FIELD_W;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

   typedef enum logic [1:0] {
      KIND_NORMAL,
      KIND_A,
      KIND_M
   } kind_type;

   function automatic logic [FRAC_BITS-1:0] to_frac(input logic [FIELD_W-1:0] v);
      logic [FEXT_W-1:0] e;
      e = FEXT_W'(v);
      return e[FRAC_BITS-1:0];
   endfunction

   function automatic logic [COUNT_BITS-1:0] to_count(input logic [FIELD_W-1:0] v);
      logic [CEXT_W-1:0] e;
      e = CEXT_W'(v);
      return e[COUNT_BITS-1:0];
   endfunction

   function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] c,
                                                     input logic [1:0] k);
      logic [COUNT_BITS:0] s;
      s = (COUNT_BITS+1)'(c) + (COUNT_BITS+1)'(k);
      return s[COUNT_BITS] ? CNT_MAX : s[COUNT_BITS-1:0];
   endfunction

   function automatic logic [TOT_W-1:0] total_of(input logic [COUNT_BITS-1:0] n,
                                                 input logic [COUNT_BITS-1:0] a,
                                                 input logic [COUNT_BITS-1:0] m,
                                                 input logic [COUNT_BITS-1:0] d);
      return TOT_W'(n) + TOT_W'(a) + TOT_W'(m) + TOT_W'(d);
   endfunction

   logic [FRAC_BITS-1:0] pick, sec, tany, ta, a_one, a_two, m_one, m_two;
   logic [TOT_W-1:0]     tot, sum_na, sum_nam, tot_next;
   logic [PROD_W-1:0]    pt, hany, ha, lim_n, lim_na, lim_nam;
   logic                 empty, full_now;
   kind_type             k1, k2;
   logic [1:0]           inc_n, inc_a, inc_m;

   assign pick  = to_frac(rand_pick_i);
   assign sec   = to_frac(rand_second_i);
   assign tany  = to_frac(cfg_i.thr_n_mutate_any);
   assign ta    = to_frac(cfg_i.thr_n_mutate_a);
   assign a_one = to_frac(cfg_i.thr_a_one);
   assign a_two = to_frac(cfg_i.thr_a_two);
   assign m_one = to_frac(cfg_i.thr_m_one);
   assign m_two = to_frac(cfg_i.thr_m_two);

   assign tot      = total_of(normal_i, a_i, m_i, double_i);
   assign sum_na   = TOT_W'(normal_i) + TOT_W'(a_i);
   assign sum_nam  = sum_na + TOT_W'(m_i);
   assign empty    = (tot == '0);
   assign full_now = (CMP_W'(tot) >= CMP_W'(cfg_i.max_total));

   assign pt      = PROD_W'(tot) * PROD_W'(pick);
   assign hany    = PROD_W'(tany) * PROD_W'(normal_i);
   assign ha      = PROD_W'(ta) * PROD_W'(normal_i);
   assign lim_n   = PROD_W'(normal_i) << FRAC_BITS;
   assign lim_na  = PROD_W'(sum_na) << FRAC_BITS;
   assign lim_nam = PROD_W'(sum_nam) << FRAC_BITS;

   always_comb begin
      if (hany < pt) begin
         k1 = KIND_NORMAL;
      end else if (ha < pt) begin
         k1 = KIND_M;
      end else begin
         k1 = KIND_A;
      end
      if (sec > tany) begin
         k2 = KIND_NORMAL;
      end else if (sec > ta) begin
         k2 = KIND_M;
      end else begin
         k2 = KIND_A;
      end
      inc_n = {1'b0, k1 == KIND_NORMAL} + {1'b0, k2 == KIND_NORMAL};
      inc_a = {1'b0, k1 == KIND_A} + {1'b0, k2 == KIND_A};
      inc_m = {1'b0, k1 == KIND_M} + {1'b0, k2 == KIND_M};
   end

   always_comb begin
      normal_o = normal_i;
      a_o      = a_i;
      m_o      = m_i;
      double_o = double_i;
      if (func_i == FUNC_LOAD) begin
         normal_o = to_count(load_normal_i);
         a_o      = to_count(load_a_i);
         m_o      = to_count(load_m_i);
         double_o = to_count(load_double_i);
      end else if (!empty && !full_now) begin
         if (pt < lim_n) begin
            normal_o = sat_add(normal_i - COUNT_BITS'(1), inc_n);
            a_o      = sat_add(a_i, inc_a);
            m_o      = sat_add(m_i, inc_m);
         end else if (pt < lim_na) begin
            if (sec > a_one) begin
               a_o = sat_add(a_i, 2'd1);
            end else if (sec > a_two) begin
               double_o = sat_add(double_i, 2'd1);
            end else begin
               a_o      = a_i - COUNT_BITS'(1);
               double_o = sat_add(double_i, 2'd2);
            end
         end else if (pt < lim_nam) begin
            if (sec > m_one) begin
               m_o = sat_add(m_i, 2'd1);
            end else if (sec > m_two) begin
               double_o = sat_add(double_i, 2'd1);
            end else begin
               m_o      = m_i - COUNT_BITS'(1);
               double_o = sat_add(double_i, 2'd2);
            end
         end else begin
            double_o = sat_add(double_i, 2'd1);
         end
      end
   end

   assign tot_next  = total_of(normal_o, a_o, m_o, double_o);
   assign extinct_o = (tot_next == '0);
   assign full_o    = (CMP_W'(tot_next) >= CMP_W'(cfg_i.max_total));

endmodule

`default_nettype wire

>>> rtl/core/growth_mutation_birth_step_top.sv
// A request accepted into the request register is held there until it can advance, which a
// response waiting on rsp_tready stalls; when it advances, its response is registered.
// Throughput: one request per cycle; req_tready drops only while a response waits on rsp_tready.
// The registered population counts feed back through the combinational step logic.
// Reset is synchronous: counts clear to zero, thresholds take their defaults,
// both stages empty. No clearing pass follows reset.
`default_nettype none

module growth_mutation_birth_step_top #(
   parameter int COUNT_BITS = gmb_pkg::DEFAULT_COUNT_BITS,
   parameter int FRAC_BITS  = gmb_pkg::DEFAULT_FRAC_BITS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // load_normal, load_a, load_m, load_double, rand_pick, rand_second
   input  wire logic [gmb_pkg::REQ_DATA_W-1:0] req_tdata,
   // func
   input  wire logic                           req_tuser,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // count_normal, count_a, count_m, count_double
   output logic      [gmb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // grown_full, extinct
   output logic      [gmb_pkg::RSP_USER_W-1:0] rsp_tuser,
   input  wire logic                           csr_wen,
   input  wire logic [gmb_pkg::IDX_W-1:0]      csr_index,
   input  wire logic [gmb_pkg::CFG_W-1:0]      csr_wdata
);
   import gmb_pkg::*;

   localparam int TOT_W  = COUNT_BITS + 2;
   localparam int OEXT_W = (COUNT_BITS > FIELD_W) ? COUNT_BITS : FIELD_W;

   function automatic logic [FIELD_W-1:0] to_field(input logic [COUNT_BITS-1:0] c);
      logic [OEXT_W-1:0] e;
      e = OEXT_W'(c);
      return e[FIELD_W-1:0];
   endfunction

   cfg_type cfg;

   logic                  in_valid_ff, in_func_ff;
   logic [REQ_DATA_W-1:0] in_data_ff;
   logic                  out_valid_ff;
   logic [RSP_DATA_W-1:0] out_data_ff;
   logic [RSP_USER_W-1:0] out_user_ff;
   logic [COUNT_BITS-1:0] normal_ff, a_ff, m_ff, double_ff;
   logic [COUNT_BITS-1:0] normal_in, a_in, m_in, double_in;
   logic                  full_in, extinct_in, advance;
   logic [TOT_W-1:0]      tot_now;

   gmb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg_o     (cfg)
   );

   gmb_step #(
      .COUNT_BITS (COUNT_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_step (
      .cfg_i         (cfg),
      .func_i        (in_func_ff),
      .load_normal_i (in_data_ff[0*FIELD_W +: FIELD_W]),
      .load_a_i      (in_data_ff[1*FIELD_W +: FIELD_W]),
      .load_m_i      (in_data_ff[2*FIELD_W +: FIELD_W]),
      .load_double_i (in_data_ff[3*FIELD_W +: FIELD_W]),
      .rand_pick_i   (in_data_ff[4*FIELD_W +: FIELD_W]),
      .rand_second_i (in_data_ff[5*FIELD_W +: FIELD_W]),
      .normal_i      (normal_ff),
      .a_i           (a_ff),
      .m_i           (m_ff),
      .double_i      (double_ff),
      .normal_o      (normal_in),
      .a_o           (a_in),
      .m_o           (m_in),
      .double_o      (double_in),
      .full_o        (full_in),
      .extinct_o     (extinct_in)
   );

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign tot_now    = TOT_W'(normal_ff) + TOT_W'(a_ff) + TOT_W'(m_ff) + TOT_W'(double_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         normal_ff    <= '0;
         a_ff         <= '0;
         m_ff         <= '0;
         double_ff    <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            normal_ff    <= normal_in;
            a_ff         <= a_in;
            m_ff         <= m_in;
            double_ff    <= double_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_func_ff <= req_tuser;
         in_data_ff <= req_tdata;
      end
      if (advance) begin
         out_data_ff <= {to_field(double_in), to_field(m_in),
                         to_field(a_in), to_field(normal_in)};
         out_user_ff <= {extinct_in, full_in};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

`ifndef SYNTHESIS
   a_extinct_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata == '0)
      else $error("extinct response carries nonzero counts");

   a_birth_growth : assert property (@(posedge clock) disable iff (reset)
      advance && in_func_ff == FUNC_BIRTH |=>
         (TOT_W+1)'(tot_now) <= (TOT_W+1)'($past(tot_now)) + (TOT_W+1)'(1))
      else $error("birth grew the population by more than one");

   a_empty_stays : assert property (@(posedge clock) disable iff (reset)
      advance && in_func_ff == FUNC_BIRTH && tot_now == '0 |=> tot_now == '0)
      else $error("birth on an empty population changed the counts");

   a_stage_moves : assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("request left its stage without a response");
`endif

endmodule

`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for growth_mutation_birth_step_top: drives load and birth requests,
// predicts the four population counts and the full/extinct flags, checks every response.
// Depends on gmb_pkg and the RTL top level only.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
   import gmb_pkg::*;

   localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
   localparam int RANDOM_PHASES = 5;
   localparam int PER_PHASE     = 160;
   localparam int SETTLE_CYCLES = 4;

   typedef struct packed {
      logic        func;
      logic [31:0] load_normal;
      logic [31:0] load_a;
      logic [31:0] load_m;
      logic [31:0] load_double;
      logic [31:0] rand_pick;
      logic [31:0] rand_second;
   } pop_req_type;

   typedef struct packed {
      logic [31:0] count_normal;
      logic [31:0] count_a;
      logic [31:0] count_m;
      logic [31:0] count_double;
      logic        grown_full;
      logic        extinct;
   } pop_rsp_type;

   typedef struct {
      pop_req_type req;
      bit          known;
      pop_rsp_type want;
   } dir_row_type;

   typedef enum logic [1:0] {KID_NORMAL, KID_A, KID_M} kid_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = FUNC_LOAD;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_wen = 1'b0;
   logic [IDX_W-1:0]      csr_index = REG_THR_N_ANY;
   logic [CFG_W-1:0]      csr_wdata = '0;

   // predictor state
   cfg_type     thr_cfg;
   logic [31:0] pop_n, pop_a, pop_m, pop_d;

   pop_rsp_type expected_counts[$];
   int          error_count = 0;
   int          gap_pct = 0;
   int          stall_pct = 0;
   pop_rsp_type got_rsp, want_rsp;

   growth_mutation_birth_step_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   function automatic logic [31:0] bump(logic [31:0] c, logic [1:0] k);
      logic [32:0] s;
      s = 33'(c) + 33'(k);
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic logic [33:0] population_total();
      return 34'(pop_n) + 34'(pop_a) + 34'(pop_m) + 34'(pop_d);
   endfunction

   task automatic add_kid(input kid_type k);
      case (k)
         KID_NORMAL: pop_n = bump(pop_n, 2'd1);
         KID_A:      pop_a = bump(pop_a, 2'd1);
         default:    pop_m = bump(pop_m, 2'd1);
      endcase
   endtask

   task automatic split_mutant(inout logic [31:0] cnt,
                               input logic [31:0] sec, one, two);
      if (sec > one) begin
         cnt = bump(cnt, 2'd1);
      end else if (sec > two) begin
         pop_d = bump(pop_d, 2'd1);
      end else begin
         cnt   = cnt - 32'd1;
         pop_d = bump(pop_d, 2'd2);
      end
   endtask

   task automatic step_population(input pop_req_type r, output pop_rsp_type o);
      logic [33:0] total, cum;
      logic [67:0] pt;
      logic [63:0] h_any, h_a;
      kid_type     k1, k2;
      if (r.func == FUNC_LOAD) begin
         pop_n = r.load_normal;
         pop_a = r.load_a;
         pop_m = r.load_m;
         pop_d = r.load_double;
      end else begin
         total = population_total();
         if (total != 0 && total < 34'(thr_cfg.max_total)) begin
            pt  = 68'(total) * 68'(r.rand_pick);
            cum = 34'(pop_n);
            if (pt < 68'({cum, 32'd0})) begin
               h_any = 64'(thr_cfg.thr_n_mutate_any) * 64'(pop_n);
               h_a   = 64'(thr_cfg.thr_n_mutate_a) * 64'(pop_n);
               pop_n = pop_n - 32'd1;
               k1 = (68'(h_any) < pt) ? KID_NORMAL : ((68'(h_a) < pt) ? KID_M : KID_A);
               k2 = (r.rand_second > thr_cfg.thr_n_mutate_any) ? KID_NORMAL :
                    ((r.rand_second > thr_cfg.thr_n_mutate_a) ? KID_M : KID_A);
               add_kid(k1);
               add_kid(k2);
            end else begin
               cum = cum + 34'(pop_a);
               if (pt < 68'({cum, 32'd0})) begin
                  split_mutant(pop_a, r.rand_second, thr_cfg.thr_a_one, thr_cfg.thr_a_two);
               end else begin
                  cum = cum + 34'(pop_m);
                  if (pt < 68'({cum, 32'd0})) begin
                     split_mutant(pop_m, r.rand_second, thr_cfg.thr_m_one,
                                  thr_cfg.thr_m_two);
                  end else begin
                     pop_d = bump(pop_d, 2'd1);
                  end
               end
            end
         end
      end
      total = population_total();
      o.count_normal = pop_n;
      o.count_a      = pop_a;
      o.count_m      = pop_m;
      o.count_double = pop_d;
      o.grown_full   = (total >= 34'(thr_cfg.max_total));
      o.extinct      = (total == 0);
   endtask

   function automatic pop_req_type ld(logic [31:0] n, a, m, d);
      pop_req_type r;
      r = '0;
      r.func = FUNC_LOAD;
      r.load_normal = n;
      r.load_a = a;
      r.load_m = m;
      r.load_double = d;
      r.rand_pick = $urandom;
      r.rand_second = $urandom;
      return r;
   endfunction

   function automatic pop_req_type br(logic [31:0] pick, sec);
      pop_req_type r;
      r = '0;
      r.func = FUNC_BIRTH;
      r.load_normal = $urandom;
      r.load_a = $urandom;
      r.load_m = $urandom;
      r.load_double = $urandom;
      r.rand_pick = pick;
      r.rand_second = sec;
      return r;
   endfunction

   function automatic pop_rsp_type counts(logic [31:0] n, a, m, d, logic full, empty);
      return '{n, a, m, d, full, empty};
   endfunction

   function automatic logic [31:0] random_count();
      case ($urandom_range(0, 9))
         0, 1:    return 32'd0;
         7, 8:    return $urandom_range(0, 32'h0010_0000);
         9:       return $urandom;
         default: return $urandom_range(0, 20);
      endcase
   endfunction

   // aim near a threshold so the strict compares get hit on both sides
   function automatic logic [31:0] random_second();
      logic [31:0] base;
      if ($urandom_range(0, 1) == 0) return $urandom;
      case ($urandom_range(0, 5))
         0:       base = thr_cfg.thr_n_mutate_any;
         1:       base = thr_cfg.thr_n_mutate_a;
         2:       base = thr_cfg.thr_a_one;
         3:       base = thr_cfg.thr_a_two;
         4:       base = thr_cfg.thr_m_one;
         default: base = thr_cfg.thr_m_two;
      endcase
      return base + 32'($urandom_range(0, 4)) - 32'd2;
   endfunction

   function automatic pop_req_type random_request();
      logic [33:0] total;
      int          load_pct;
      total    = population_total();
      load_pct = (total == 0 || total >= 34'(thr_cfg.max_total)) ? 70 : 6;
      if ($urandom_range(0, 99) < load_pct)
         return ld(random_count(), random_count(), random_count(), random_count());
      return br(($urandom_range(0, 4) == 0) ? $urandom_range(0, 32'h0001_0000) : $urandom,
                random_second());
   endfunction

   task automatic set_pace(input int mode);
      case (mode % 4)
         0:       begin gap_pct = 0;  stall_pct = 0;  end
         1:       begin gap_pct = 62; stall_pct = 0;  end
         2:       begin gap_pct = 0;  stall_pct = 62; end
         default: begin gap_pct = 28; stall_pct = 28; end
      endcase
   endtask

   task automatic send_request(input pop_req_type r, input bit known,
                               input pop_rsp_type want);
      pop_rsp_type pred;
      while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.func;
      req_tdata  <= {r.rand_second, r.rand_pick, r.load_double, r.load_m, r.load_a,
                     r.load_normal};
      do @(posedge clock); while (!req_tready);
      step_population(r, pred);
      expected_counts.push_back(known ? want : pred);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_counts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_put(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic program_regs(input cfg_type c);
      csr_put(REG_THR_N_ANY, c.thr_n_mutate_any);
      csr_put(REG_THR_N_A,   c.thr_n_mutate_a);
      csr_put(REG_THR_A_ONE, c.thr_a_one);
      csr_put(REG_THR_A_TWO, c.thr_a_two);
      csr_put(REG_THR_M_ONE, c.thr_m_one);
      csr_put(REG_THR_M_TWO, c.thr_m_two);
      csr_put(REG_MAX_TOTAL, c.max_total);
      // unmapped index must leave the map untouched
      csr_put(REG_UNUSED, $urandom);
      csr_wen <= 1'b0;
      thr_cfg = c;
   endtask

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_rsp = {rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64], rsp_tdata[127:96],
                    rsp_tuser[0], rsp_tuser[1]};
         if (expected_counts.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected response n=%0d a=%0d m=%0d d=%0d full=%0b ext=%0b",
                        got_rsp.count_normal, got_rsp.count_a, got_rsp.count_m,
                        got_rsp.count_double, got_rsp.grown_full, got_rsp.extinct);
         end else begin
            want_rsp = expected_counts.pop_front();
            if (got_rsp !== want_rsp) begin
               error_count++;
               if (error_count <= 10)
                  $display({"mismatch exp n=%0d a=%0d m=%0d d=%0d full=%0b ext=%0b",
                            " got n=%0d a=%0d m=%0d d=%0d full=%0b ext=%0b"},
                           want_rsp.count_normal, want_rsp.count_a, want_rsp.count_m,
                           want_rsp.count_double, want_rsp.grown_full, want_rsp.extinct,
                           got_rsp.count_normal, got_rsp.count_a, got_rsp.count_m,
                           got_rsp.count_double, got_rsp.grown_full, got_rsp.extinct);
            end
         end
      end
   end

   initial begin
      #(5_000_000);
      $display("status: fail");
      $finish;
   end

   initial begin
      dir_row_type dir_rows[$];
      cfg_type     phase_cfg[RANDOM_PHASES];
      logic [31:0] ones;
      ones = 32'hFFFF_FFFF;
      thr_cfg = '{RST_THR_N_ANY, RST_THR_N_A, RST_THR_A_ONE, RST_THR_A_TWO,
                  RST_THR_M_ONE, RST_THR_M_TWO, RST_MAX_TOTAL};
      pop_n = '0;
      pop_a = '0;
      pop_m = '0;
      pop_d = '0;

      dir_rows.push_back('{br(0, 0), 1'b1, counts(0, 0, 0, 0, 1'b0, 1'b1)});
      dir_rows.push_back('{ld(0, 0, 0, 0), 1'b1, counts(0, 0, 0, 0, 1'b0, 1'b1)});
      dir_rows.push_back('{ld(ones, ones, ones, ones), 1'b1,
                           counts(ones, ones, ones, ones, 1'b1, 1'b0)});
      dir_rows.push_back('{br(32'h8000_0000, 0), 1'b1,
                           counts(ones, ones, ones, ones, 1'b1, 1'b0)});
      dir_rows.push_back('{ld(32'h7FFF_FFFF, 0, 0, 1), 1'b1,
                           counts(32'h7FFF_FFFF, 0, 0, 1, 1'b1, 1'b0)});
      dir_rows.push_back('{br(0, 0), 1'b1, counts(32'h7FFF_FFFF, 0, 0, 1, 1'b1, 1'b0)});
      dir_rows.push_back('{ld(10, 0, 0, 0), 1'b1, counts(10, 0, 0, 0, 1'b0, 1'b0)});
      dir_rows.push_back('{br(0, ones), 1'b0, '0});
      dir_rows.push_back('{br(ones, 0), 1'b0, '0});
      dir_rows.push_back('{br(32'h0000_1000, 32'd429), 1'b0, '0});
      dir_rows.push_back('{br(0, 32'd430), 1'b0, '0});
      dir_rows.push_back('{br(32'h7FFF_FFFF, 32'd4725), 1'b0, '0});
      dir_rows.push_back('{ld(0, 5, 0, 0), 1'b1, counts(0, 5, 0, 0, 1'b0, 1'b0)});
      dir_rows.push_back('{br(0, ones), 1'b0, '0});
      dir_rows.push_back('{br(0, 1), 1'b0, '0});
      dir_rows.push_back('{br(0, 0), 1'b0, '0});
      dir_rows.push_back('{ld(0, 0, 5, 0), 1'b1, counts(0, 0, 5, 0, 1'b0, 1'b0)});
      dir_rows.push_back('{br(0, ones), 1'b0, '0});
      dir_rows.push_back('{br(0, 0), 1'b0, '0});
      dir_rows.push_back('{br(0, 32'd85899), 1'b0, '0});
      dir_rows.push_back('{ld(0, 0, 0, 7), 1'b1, counts(0, 0, 0, 7, 1'b0, 1'b0)});
      dir_rows.push_back('{br(ones, 32'h5555_5555), 1'b0, '0});
      dir_rows.push_back('{ld(2, 3, 4, 5), 1'b1, counts(2, 3, 4, 5, 1'b0, 1'b0)});
      dir_rows.push_back('{br(32'hAAAA_AAAA, 32'h5555_5555), 1'b0, '0});
      dir_rows.push_back('{br(32'h5555_5555, 32'hAAAA_AAAA), 1'b0, '0});

      phase_cfg[0] = '{32'h8000_0000, 32'h4000_0000, 32'h8000_0000, 32'h2000_0000,
                       32'hC000_0000, 32'h4000_0000, 32'd200};
      phase_cfg[1] = '{ones, ones, ones, ones, ones, ones, ones};
      phase_cfg[2] = '{0, 0, 0, 0, 0, 0, 0};
      phase_cfg[3] = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom_range(1, 500)};
      phase_cfg[4] = '{32'h1000_0000, 32'h0800_0000, 32'h3000_0000, 32'h0100_0000,
                       32'h6000_0000, 32'h0200_0000, 32'd1};

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_pace(0);
      foreach (dir_rows[i]) send_request(dir_rows[i].req, dir_rows[i].known, dir_rows[i].want);
      wait_drained();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         program_regs(phase_cfg[p]);
         for (int half = 0; half < 2; half++) begin
            set_pace(2 * p + half);
            for (int i = 0; i < PER_PHASE / 2; i++) send_request(random_request(), 1'b0, '0);
            wait_drained();
         end
      end

      // restore defaults and run a last stretch on them
      program_regs('{RST_THR_N_ANY, RST_THR_N_A, RST_THR_A_ONE, RST_THR_A_TWO,
                     RST_THR_M_ONE, RST_THR_M_TWO, RST_MAX_TOTAL});
      set_pace(3);
      for (int i = 0; i < 40; i++) send_request(random_request(), 1'b0, '0);
      wait_drained();

      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
